// File: rtl/cksb_pkg.sv
// ----------------------------------------------------------------------------
// Color-keyed sprite blitter package
// Shared types, register codes, draw modes and RGB565 constants.
// ----------------------------------------------------------------------------
package cksb_pkg;

  localparam int DEFAULT_SCREEN_WIDTH = 384;

  localparam int ADDR_W      = 17;
  localparam int PIXEL_W     = 16;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;
  localparam int SIZE_W      = 9;
  localparam int ALPHA_W     = 5;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLOR     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DRAW_MODE     = 3'd6;

  // Draw modes. The unused code behaves as a keyed copy.
  localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLIP  = 2'd2;

  // RGB565 blend constants and the reset key color.
  localparam logic [PIXEL_W-1:0] RB_MASK      = 16'hF81F;
  localparam logic [PIXEL_W-1:0] G_MASK       = 16'h07E0;
  localparam logic [PIXEL_W-1:0] RB_ROUND     = 16'h8010;
  localparam logic [PIXEL_W-1:0] G_ROUND      = 16'h0400;
  localparam logic [PIXEL_W-1:0] KEY_RESET    = 16'h4FE0;
  localparam logic [ALPHA_W:0]   ALPHA_ONE    = 6'd32;

  typedef struct packed {
    logic [PIXEL_W-1:0] src_pixel;
    logic [PIXEL_W-1:0] dst_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  fb_address;
    logic [PIXEL_W-1:0] pixel_out;
    logic               write_enable;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   origin_x;
    logic [ROW_W-1:0]   origin_y;
    logic [SIZE_W-1:0]  sprite_width;
    logic [SIZE_W-1:0]  sprite_height;
    logic [PIXEL_W-1:0] key_color;
    logic [ALPHA_W-1:0] blend_alpha;
    logic [MODE_W-1:0]  draw_mode;
  } cfg_t;

  // Position of the next pixel within the sprite.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } scan_t;

  // A size of zero behaves as a size of one.
  function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
    effective_size = (size == '0) ? SIZE_W'(1) : size;
  endfunction

endpackage

// File: rtl/color_keyed_sprite_blitter_top.sv
// ----------------------------------------------------------------------------
// Color-keyed sprite blitter
// Streams RGB565 sprite pixels and produces framebuffer writes with
// color keying, horizontal flip and alpha blend.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in      | input     | in_valid/in_ready   | in_data  (src, dst pixel)
//   out     | output    | out_valid/out_ready | out_data (address, pixel,
//           |           |                     |           write, last)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One request per cycle while out takes results; an accepted request is loaded
// into the input register and then into the result register, from which it
// is offered on out.
// The scan counters step on acceptance, so the sprite position travels with
// the request. Reset clears the counters and the valid flags and sets the configuration registers to their defaults.
// A stall on out holds the result register; the input register keeps taking
// requests until both stages are full.
//
module color_keyed_sprite_blitter_top #(
  parameter int SCREEN_WIDTH = cksb_pkg::DEFAULT_SCREEN_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cksb_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cksb_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [cksb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cksb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cksb_pkg::*;

  localparam logic [ADDR_W-1:0] SCREEN_WIDTH_A = ADDR_W'(SCREEN_WIDTH);

  cfg_t  cfg;
  scan_t scan;

  logic in_fire;
  logic s1_advance;

  // Input register.
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_src;
  logic [PIXEL_W-1:0] s1_dst;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_last;

  // Stage two logic.
  logic [SIZE_W-1:0]  w_eff;
  logic [COL_W-1:0]   target;
  logic [ROW_W:0]     row_sum;
  logic [ADDR_W-1:0]  row_base;
  logic [ADDR_W-1:0]  address;
  logic [PIXEL_W-1:0] pixel;
  logic               we;
  out_item_t          result_next;

  cksb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cksb_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .advance       (in_fire),
    .sprite_width  (cfg.sprite_width),
    .sprite_height (cfg.sprite_height),
    .scan          (scan)
  );

  cksb_pixel u_pixel (
    .src_pixel    (s1_src),
    .dst_pixel    (s1_dst),
    .key_color    (cfg.key_color),
    .blend_alpha  (cfg.blend_alpha),
    .draw_mode    (cfg.draw_mode),
    .pixel_out    (pixel),
    .write_enable (we)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    w_eff = effective_size(cfg.sprite_width);
    // A flipped column wraps modulo the counter width when it underflows.
    if (cfg.draw_mode == MODE_FLIP) begin
      target = w_eff - SIZE_W'(1) - s1_col;
    end else begin
      target = s1_col;
    end
    row_sum  = (ROW_W+1)'(cfg.origin_y) + (ROW_W+1)'(s1_row);
    row_base = ADDR_W'(row_sum) * SCREEN_WIDTH_A;
    address  = row_base + ADDR_W'(cfg.origin_x) + ADDR_W'(target);

    result_next.fb_address   = address;
    result_next.pixel_out    = pixel;
    result_next.write_enable = we;
    result_next.last_pixel   = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_src  <= in_data.src_pixel;
      s1_dst  <= in_data.dst_pixel;
      s1_col  <= scan.col;
      s1_row  <= scan.row;
      s1_last <= scan.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted request did not reach the input register");

  a_stage1_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("input register advanced without a result");

  a_stage1_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=>
      (s1_valid && $stable(s1_src) && $stable(s1_dst) && $stable(s1_col)
       && $stable(s1_row) && $stable(s1_last)))
    else $error("input register changed while the output was stalled");

  a_counters_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && scan.last) |=> (scan.col == '0 && scan.row == '0))
    else $error("scan counters did not wrap after the final pixel");
`endif

endmodule

// File: rtl/cksb_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds origin, size, key color, alpha and draw mode, written by index.
// ----------------------------------------------------------------------------
module cksb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cksb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cksb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cksb_pkg::cfg_t                    cfg
);
  import cksb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.sprite_width  <= SIZE_W'(1);
      cfg.sprite_height <= SIZE_W'(1);
      cfg.key_color     <= KEY_RESET;
      cfg.blend_alpha   <= '0;
      cfg.draw_mode     <= MODE_COPY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x      <= cfg_data[COL_W-1:0];
        REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data[ROW_W-1:0];
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[SIZE_W-1:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[SIZE_W-1:0];
        REG_KEY_COLOR:     cfg.key_color     <= cfg_data[PIXEL_W-1:0];
        REG_BLEND_ALPHA:   cfg.blend_alpha   <= cfg_data[ALPHA_W-1:0];
        REG_DRAW_MODE:     cfg.draw_mode     <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/cksb_scan.sv
// ----------------------------------------------------------------------------
// Sprite scan counters
// Column and row counters that step once per accepted request.
// ----------------------------------------------------------------------------
module cksb_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [cksb_pkg::SIZE_W-1:0]   sprite_width,
  input  logic [cksb_pkg::SIZE_W-1:0]   sprite_height,
  output cksb_pkg::scan_t               scan
);
  import cksb_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W:0]   col_plus;
  logic [SIZE_W:0]   row_plus;
  logic              end_row;
  logic              end_all;

  always_comb begin
    w_eff    = effective_size(sprite_width);
    h_eff    = effective_size(sprite_height);
    col_plus = (SIZE_W+1)'(column_count) + (SIZE_W+1)'(1);
    row_plus = (SIZE_W+1)'(row_count) + (SIZE_W+1)'(1);
    // Compare with >= so a size lowered mid-sprite still ends the row.
    end_row  = col_plus >= (SIZE_W+1)'(w_eff);
    end_all  = end_row && (row_plus >= (SIZE_W+1)'(h_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (end_row) begin
        column_count <= '0;
        row_count    <= end_all ? '0 : row_plus[ROW_W-1:0];
      end else begin
        column_count <= col_plus[COL_W-1:0];
      end
    end
  end

  assign scan.col  = column_count;
  assign scan.row  = row_count;
  assign scan.last = end_all;

endmodule

// File: rtl/cksb_pixel.sv
// ----------------------------------------------------------------------------
// Pixel datapath
// Key test and RGB565 alpha blend for one sprite pixel.
// ----------------------------------------------------------------------------
module cksb_pixel (
  input  logic [cksb_pkg::PIXEL_W-1:0] src_pixel,
  input  logic [cksb_pkg::PIXEL_W-1:0] dst_pixel,
  input  logic [cksb_pkg::PIXEL_W-1:0] key_color,
  input  logic [cksb_pkg::ALPHA_W-1:0] blend_alpha,
  input  logic [cksb_pkg::MODE_W-1:0]  draw_mode,
  output logic [cksb_pkg::PIXEL_W-1:0] pixel_out,
  output logic                         write_enable
);
  import cksb_pkg::*;

  logic [ALPHA_W:0]   alpha_inv;
  logic [21:0]        rb_sum;
  logic [17:0]        g_sum;
  logic [PIXEL_W-1:0] rb_val;
  logic [PIXEL_W-1:0] g_val;
  logic [PIXEL_W-1:0] blended;

  always_comb begin
    alpha_inv = ALPHA_ONE - (ALPHA_W+1)'(blend_alpha);
    rb_sum = 22'(src_pixel & RB_MASK) * 22'(blend_alpha)
           + 22'(dst_pixel & RB_MASK) * 22'(alpha_inv)
           + 22'(RB_ROUND);
    g_sum  = 18'(src_pixel & G_MASK) * 18'(blend_alpha)
           + 18'(dst_pixel & G_MASK) * 18'(alpha_inv)
           + 18'(G_ROUND);
    rb_val  = rb_sum[PIXEL_W+4:5] & RB_MASK;
    // Green is shifted by six, one more than red and blue.
    g_val   = PIXEL_W'(g_sum[PIXEL_W+1:6]) & G_MASK;
    blended = rb_val | g_val;

    write_enable = (src_pixel != key_color);
    if (!write_enable) begin
      pixel_out = dst_pixel;
    end else if (draw_mode == MODE_BLEND) begin
      pixel_out = blended;
    end else begin
      pixel_out = src_pixel;
    end
  end

endmodule
